// ===== rtl/preemptive_priority_scheduler_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Preemptive priority scheduler assertion macros
// Shared property forms for the scheduler checkers.
// ---------------------------------------------------------------------------
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define PPSU_ASSERT_SAME(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");

// Consequent must hold in the cycle after the antecedent
`define PPSU_ASSERT_NEXT(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");

`endif

// ===== rtl/ppsu_pkg.sv =====
// ---------------------------------------------------------------------------
// Preemptive priority scheduler package
// Item layouts, slot entry layout, sequencer states and control groups.
// ---------------------------------------------------------------------------
package ppsu_pkg;

	localparam int TIME_W = 16;
	localparam int PRIO_W = 8;
	localparam int ACC_W  = 32;

	localparam logic [ACC_W-1:0] ACC_MAX = '1;

	// Request kinds
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [2:0]        slot;
		logic [TIME_W-1:0] arrival_time;
		logic [TIME_W-1:0] burst_length;
		logic [PRIO_W-1:0] prio_level;
	} req_t;

	typedef struct packed {
		logic             idle;
		logic [2:0]       run_slot;
		logic             finished;
		logic [ACC_W-1:0] completion_time;
		logic [ACC_W-1:0] turnaround_time;
		logic [ACC_W-1:0] waiting_time;
		logic [ACC_W-1:0] sum_waiting;
		logic [ACC_W-1:0] sum_turnaround;
		logic             all_done;
	} rsp_t;

	typedef struct packed {
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] burst;
		logic [TIME_W-1:0] remaining;
		logic [PRIO_W-1:0] prio;
	} slot_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EXEC,
		ST_TURN,
		ST_WAIT,
		ST_SUM,
		ST_OUT
	} state_t;

	// Status from the datapath to the sequencer
	typedef struct packed {
		logic req_valid;
		logic req_tick;
		logic found;
		logic last_unit;
		logic out_free;
	} stat_t;

	// Strobes from the sequencer to the datapath
	typedef struct packed {
		logic in_ready;
		logic scan;
		logic exec;
		logic turn;
		logic calc_wait;
		logic sum;
		logic out_load;
	} ctrl_t;

endpackage

// ===== rtl/ppsu_if.sv =====
// ---------------------------------------------------------------------------
// Preemptive priority scheduler channels
// Valid/ready channels for request items and result items.
// ---------------------------------------------------------------------------
interface ppsu_req_if;
	import ppsu_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ppsu_rsp_if;
	import ppsu_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ppsu_cmp.sv =====
// ---------------------------------------------------------------------------
// Preemptive priority scheduler candidate comparator
// Shared compare unit: tests one slot per cycle against the best so far.
// ---------------------------------------------------------------------------
module ppsu_cmp (
	input  logic                        cand_valid,
	input  logic [ppsu_pkg::TIME_W-1:0] cand_arr,
	input  logic [ppsu_pkg::PRIO_W-1:0] cand_prio,
	input  logic [ppsu_pkg::ACC_W-1:0]  now,
	input  logic                        best_found,
	input  logic [ppsu_pkg::TIME_W-1:0] best_arr,
	input  logic [ppsu_pkg::PRIO_W-1:0] best_prio,
	output logic                        take
);
	import ppsu_pkg::*;

	logic eligible;
	logic better;

	// Slot has work and has arrived by the current time
	assign eligible = cand_valid && ({{(ACC_W-TIME_W){1'b0}}, cand_arr} <= now);

	// Lower priority number wins, then earlier arrival; later index never wins a tie
	assign better = !best_found || (cand_prio < best_prio) ||
		((cand_prio == best_prio) && (cand_arr < best_arr));

	assign take = eligible && better;
endmodule

// ===== rtl/ppsu_ctrl.sv =====
// ---------------------------------------------------------------------------
// Preemptive priority scheduler sequencer
// Steps a tick: scan, update, timing arithmetic when a task ends, result hand-off.
// ---------------------------------------------------------------------------
module ppsu_ctrl #(
	parameter int NUM_SLOTS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ppsu_pkg::stat_t              st,
	output ppsu_pkg::ctrl_t              ctl,
	output logic [$clog2(NUM_SLOTS)-1:0] scan_idx
);
	import ppsu_pkg::*;

	localparam int IW = $clog2(NUM_SLOTS);
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

	state_t        state_q;
	state_t        state_d;
	logic [IW-1:0] idx_q;
	logic          scan_last;

	assign scan_last = (idx_q == LAST_IDX);
	assign scan_idx  = idx_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (st.req_valid && st.req_tick) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_EXEC;
			ST_EXEC: begin
				if (st.found && st.last_unit) state_d = ST_TURN;
				else state_d = ST_OUT;
			end
			ST_TURN: state_d = ST_WAIT;
			ST_WAIT: state_d = ST_SUM;
			ST_SUM:  state_d = ST_OUT;
			ST_OUT: begin
				if (st.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Strobes
	always_comb begin
		ctl           = '0;
		ctl.in_ready  = (state_q == ST_IDLE);
		ctl.scan      = (state_q == ST_SCAN);
		ctl.exec      = (state_q == ST_EXEC);
		ctl.turn      = (state_q == ST_TURN);
		ctl.calc_wait = (state_q == ST_WAIT);
		ctl.sum       = (state_q == ST_SUM);
		ctl.out_load  = (state_q == ST_OUT) && st.out_free;
	end

	// State and slot counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SCAN) begin
				idx_q <= scan_last ? '0 : idx_q + IW'(1);
			end
		end
	end
endmodule

// ===== rtl/preemptive_priority_scheduler_unit.sv =====
// Load item: written to slot memory on acceptance, ready again on the next cycle.
// Tick item: slot scan, drain and update, then turnaround, waiting and sums when a task
// finishes, and result hand-off; one slot per cycle goes through the shared comparator.
// One item in flight; ready returns once the result sits in the output register.
// Reset clears time, totals, slot busy bits and the sequencer; slot memory is not swept.
// ---------------------------------------------------------------------------
// Preemptive priority scheduler unit
// Slot table in a small memory, scanned per tick to pick the task to run.
// ---------------------------------------------------------------------------
module preemptive_priority_scheduler_unit #(
	parameter int NUM_SLOTS = 8
) (
	input logic         clk,
	input logic         arst_n,
	ppsu_req_if.sink    req,
	ppsu_rsp_if.source  rsp
);
	import ppsu_pkg::*;

	localparam int IW = $clog2(NUM_SLOTS);
	localparam int CW = $clog2(NUM_SLOTS + 1);

	ctrl_t ctl;
	stat_t st;
	logic [IW-1:0] scan_idx;

	slot_entry_t mem [NUM_SLOTS];
	slot_entry_t rd_data_s1;
	logic        rd_valid_s1;
	logic [IW-1:0] rd_idx_s1;

	logic [NUM_SLOTS-1:0] active_q;
	logic [CW-1:0]        busy_cnt_q;
	logic [ACC_W-1:0]     now_q;
	logic [ACC_W-1:0]     acc_wait_q;
	logic [ACC_W-1:0]     acc_turn_q;

	logic              best_found_q;
	logic [IW-1:0]     best_idx_q;
	logic [TIME_W-1:0] best_arr_q;
	logic [TIME_W-1:0] best_burst_q;
	logic [TIME_W-1:0] best_rem_q;
	logic [PRIO_W-1:0] best_prio_q;

	rsp_t res_q;
	rsp_t out_q;
	logic out_valid_q;

	logic          in_acc;
	logic          tick_acc;
	logic          load_acc;
	logic [IW-1:0] load_addr;
	logic          load_busy;
	logic          take;
	logic          finish_now;
	logic [ACC_W:0] wait_diff;
	logic [ACC_W:0] wait_sum;
	logic [ACC_W:0] turn_sum;

	// Accept decode
	assign in_acc    = req.valid && ctl.in_ready;
	assign tick_acc  = in_acc && (req.data.req_type == REQ_TICK);
	assign load_acc  = in_acc && (req.data.req_type == REQ_LOAD) &&
		(int'(req.data.slot) < NUM_SLOTS);
	assign load_addr = IW'(req.data.slot);
	assign load_busy = (req.data.burst_length != '0);

	assign finish_now = ctl.exec && best_found_q && (best_rem_q == TIME_W'(1));

	// Status to the sequencer
	assign st.req_valid = req.valid;
	assign st.req_tick  = (req.data.req_type == REQ_TICK);
	assign st.found     = best_found_q;
	assign st.last_unit = (best_rem_q == TIME_W'(1));
	assign st.out_free  = !out_valid_q || rsp.ready;

	ppsu_ctrl #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.st       (st),
		.ctl      (ctl),
		.scan_idx (scan_idx)
	);

	ppsu_cmp u_cmp (
		.cand_valid (rd_valid_s1 && active_q[rd_idx_s1]),
		.cand_arr   (rd_data_s1.arrival),
		.cand_prio  (rd_data_s1.prio),
		.now        (now_q),
		.best_found (best_found_q),
		.best_arr   (best_arr_q),
		.best_prio  (best_prio_q),
		.take       (take)
	);

	// Slot memory: one write port, one registered read port for the scan
	always_ff @(posedge clk) begin
		if (load_acc) begin
			mem[load_addr] <= '{arrival:   req.data.arrival_time,
			                    burst:     req.data.burst_length,
			                    remaining: req.data.burst_length,
			                    prio:      req.data.prio_level};
		end else if (ctl.exec && best_found_q) begin
			mem[best_idx_q] <= '{arrival:   best_arr_q,
			                     burst:     best_burst_q,
			                     remaining: best_rem_q - TIME_W'(1),
			                     prio:      best_prio_q};
		end
		if (ctl.scan) begin
			rd_data_s1 <= mem[scan_idx];
		end
	end

	// Timing arithmetic: waiting-time difference, and both totals summed in one step
	assign wait_diff = {1'b0, res_q.turnaround_time} - {{(ACC_W-TIME_W+1){1'b0}}, best_burst_q};
	assign wait_sum  = {1'b0, acc_wait_q} + {1'b0, res_q.waiting_time};
	assign turn_sum  = {1'b0, acc_turn_q} + {1'b0, res_q.turnaround_time};

	// Control state: busy bits, time, totals, scan tracking, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= '0;
			busy_cnt_q   <= '0;
			now_q        <= '0;
			acc_wait_q   <= '0;
			acc_turn_q   <= '0;
			best_found_q <= 1'b0;
			rd_valid_s1  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_valid_s1 <= ctl.scan;

			// Track busy slots and their count
			priority if (load_acc) begin
				active_q[load_addr] <= load_busy;
				if (load_busy && !active_q[load_addr]) begin
					busy_cnt_q <= busy_cnt_q + CW'(1);
				end else if (!load_busy && active_q[load_addr]) begin
					busy_cnt_q <= busy_cnt_q - CW'(1);
				end
			end else if (finish_now) begin
				active_q[best_idx_q] <= 1'b0;
				busy_cnt_q           <= busy_cnt_q - CW'(1);
			end

			// Restart the search on each tick
			if (tick_acc) begin
				best_found_q <= 1'b0;
			end else if (take) begin
				best_found_q <= 1'b1;
			end

			// Advance time, holding at the top
			if (ctl.exec && (now_q != ACC_MAX)) begin
				now_q <= now_q + ACC_W'(1);
			end

			// Saturating totals
			if (ctl.sum) begin
				acc_wait_q <= wait_sum[ACC_W] ? ACC_MAX : wait_sum[ACC_W-1:0];
				acc_turn_q <= turn_sum[ACC_W] ? ACC_MAX : turn_sum[ACC_W-1:0];
			end

			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: best candidate, result fields, output register
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_idx;

		if (take) begin
			best_idx_q   <= rd_idx_s1;
			best_arr_q   <= rd_data_s1.arrival;
			best_burst_q <= rd_data_s1.burst;
			best_rem_q   <= rd_data_s1.remaining;
			best_prio_q  <= rd_data_s1.prio;
		end

		if (ctl.exec) begin
			res_q.idle            <= !best_found_q;
			res_q.run_slot        <= best_found_q ? 3'(best_idx_q) : 3'd0;
			res_q.finished        <= finish_now;
			res_q.completion_time <= '0;
			res_q.turnaround_time <= '0;
			res_q.waiting_time    <= '0;
		end
		if (ctl.turn) begin
			res_q.completion_time <= now_q;
			res_q.turnaround_time <= now_q - {{(ACC_W-TIME_W){1'b0}}, best_arr_q};
		end
		if (ctl.calc_wait) begin
			res_q.waiting_time <= wait_diff[ACC_W] ? '0 : wait_diff[ACC_W-1:0];
		end

		if (ctl.out_load) begin
			out_q <= '{idle:            res_q.idle,
			           run_slot:        res_q.run_slot,
			           finished:        res_q.finished,
			           completion_time: res_q.completion_time,
			           turnaround_time: res_q.turnaround_time,
			           waiting_time:    res_q.waiting_time,
			           sum_waiting:     acc_wait_q,
			           sum_turnaround:  acc_turn_q,
			           all_done:        (busy_cnt_q == '0)};
		end
	end

	assign req.ready = ctl.in_ready;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;
endmodule

// ===== rtl/ppsu_checker.sv =====
// ---------------------------------------------------------------------------
// Preemptive priority scheduler port checker
// Watches the request and result channels of the scheduler over time.
// ---------------------------------------------------------------------------
`include "preemptive_priority_scheduler_unit_defines.svh"

module ppsu_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           in_tick,
	input logic           out_valid,
	input logic           out_ready,
	input ppsu_pkg::rsp_t out_data
);
	import ppsu_pkg::*;

	// A tick occupies the block: no new item on the next cycle
	`PPSU_ASSERT_NEXT(a_tick_blocks, clk, arst_n, in_valid && in_ready && (in_tick == REQ_TICK), !in_ready)

	// A result appears only at the end of a tick, never out of the idle state
	`PPSU_ASSERT_SAME(a_result_after_busy, clk, arst_n, $rose(out_valid), $past(!in_ready))

	// A stalled result holds
	`PPSU_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

bind preemptive_priority_scheduler_unit ppsu_checker u_ppsu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.in_tick   (req.data.req_type),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.out_data  (rsp.data)
);
